@@ design/lzwe_pkg.sv @@
// Package for the 12-bit LZW encoder: sizes, the dictionary slot layout,
// the controller states, the result hand-off struct and the key hash.
// No dependencies.
`timescale 1ns / 1ps

package lzwe_pkg;

    localparam int DICT_ENTRIES = 4096;
    localparam int CODE_BITS    = 12;
    localparam int OUT_CODE_W   = 12;
    localparam int BYTE_W       = 8;

    localparam int ROOT_CODES = 256;
    localparam int CODE_SPACE = 1 << CODE_BITS;
    localparam int CAPACITY   = (DICT_ENTRIES > CODE_SPACE) ? CODE_SPACE : DICT_ENTRIES;

    // Hash table of DICT_ENTRIES slots; live entries never exceed CAPACITY - ROOT_CODES.
    localparam int SLOT_BITS = $clog2(DICT_ENTRIES);
    localparam int KEY_W     = CODE_BITS + BYTE_W;
    localparam int NFC_W     = $clog2(CAPACITY + 1);

    // Each dictionary clear advances the epoch; slots of older epochs read as empty.
    localparam int EPOCH_W = 6;

    typedef struct packed {
        logic [EPOCH_W-1:0]   epoch;
        logic [KEY_W-1:0]     key;
        logic [CODE_BITS-1:0] code;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_PROBE,
        ST_EMIT_MISS,
        ST_INSERT,
        ST_EMIT_LAST
    } lzwe_state_t;

    typedef struct packed {
        logic                  valid;
        logic [OUT_CODE_W-1:0] code;
        logic                  last;
    } emit_t;

    // Folds the key onto the slot index with an XOR tree.
    function automatic logic [SLOT_BITS-1:0] hash_key(input logic [KEY_W-1:0] key);
        logic [SLOT_BITS-1:0] h;
        h = '0;
        for (int i = 0; i < KEY_W; i++) begin
            h[i % SLOT_BITS] = h[i % SLOT_BITS] ^ key[i];
        end
        return h;
    endfunction

    function automatic logic [OUT_CODE_W-1:0] to_out_code(input logic [CODE_BITS-1:0] c);
        logic [OUT_CODE_W+CODE_BITS-1:0] ext;
        ext = {{OUT_CODE_W{1'b0}}, c};
        return ext[OUT_CODE_W-1:0];
    endfunction

endpackage

@@ design/lzwe_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module lzwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/lzwe_ctrl.sv @@
// Dictionary controller: hashed lookup with linear probing, insert, epoch
// clearing and the memory sweep. Depends on lzwe_pkg.
`timescale 1ns / 1ps

module lzwe_ctrl
    import lzwe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  logic [BYTE_W-1:0]    data_byte,
    input  logic                 final_byte,
    output emit_t                emit,
    input  logic                 emit_ready,
    output logic                 ram_rd_en,
    output logic [SLOT_BITS-1:0] ram_rd_addr,
    input  slot_t                ram_rd_data,
    output logic                 ram_wr_en,
    output logic [SLOT_BITS-1:0] ram_wr_addr,
    output slot_t                ram_wr_data
);

    localparam logic [EPOCH_W-1:0]   EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0]   EPOCH_LAST  = '1;
    localparam logic [NFC_W-1:0]     NFC_ROOT    = NFC_W'(ROOT_CODES);
    localparam logic [NFC_W-1:0]     NFC_FULL    = NFC_W'(CAPACITY);
    localparam logic [SLOT_BITS-1:0] SWEEP_END   = '1;

    lzwe_state_t state_reg, state_next;

    logic [CODE_BITS-1:0] pending_reg, pending_next;
    logic                 have_pending_reg, have_pending_next;
    logic [NFC_W-1:0]     next_free_reg, next_free_next;
    logic [EPOCH_W-1:0]   epoch_reg, epoch_next;
    logic [SLOT_BITS-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic                 resume_reg, resume_next;

    logic [BYTE_W-1:0]    byte_reg, byte_next;
    logic                 final_reg, final_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [SLOT_BITS-1:0] home_idx_reg, home_idx_next;
    logic [SLOT_BITS-1:0] probe_idx_reg, probe_idx_next;
    logic [SLOT_BITS-1:0] ins_idx_reg, ins_idx_next;

    logic [KEY_W-1:0]     key_in;
    logic [SLOT_BITS-1:0] hash_in;
    logic                 slot_live;
    logic                 slot_hit;
    logic                 accept;

    assign key_in    = {pending_reg, data_byte};
    assign hash_in   = hash_key(key_in);
    assign slot_live = (ram_rd_data.epoch == epoch_reg);
    assign slot_hit  = slot_live && (ram_rd_data.key == key_reg);
    assign accept    = byte_valid && !byte_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg      <= '0;
            have_pending_reg <= 1'b0;
            next_free_reg    <= NFC_ROOT;
            epoch_reg        <= '0;
            sweep_cnt_reg    <= '0;
            resume_reg       <= 1'b0;
        end
        else
        begin
            pending_reg      <= pending_next;
            have_pending_reg <= have_pending_next;
            next_free_reg    <= next_free_next;
            epoch_reg        <= epoch_next;
            sweep_cnt_reg    <= sweep_cnt_next;
            resume_reg       <= resume_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        final_reg     <= final_next;
        key_reg       <= key_next;
        home_idx_reg  <= home_idx_next;
        probe_idx_reg <= probe_idx_next;
        ins_idx_reg   <= ins_idx_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        pending_next      = pending_reg;
        have_pending_next = have_pending_reg;
        next_free_next    = next_free_reg;
        epoch_next        = epoch_reg;
        sweep_cnt_next    = sweep_cnt_reg;
        resume_next       = resume_reg;
        byte_next         = byte_reg;
        final_next        = final_reg;
        key_next          = key_reg;
        home_idx_next     = home_idx_reg;
        probe_idx_next    = probe_idx_reg;
        ins_idx_next      = ins_idx_reg;

        byte_stall  = 1'b1;
        emit        = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = probe_idx_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = ins_idx_reg;
        ram_wr_data = '{epoch: epoch_reg, key: key_reg, code: CODE_BITS'(next_free_reg)};

        unique case (state_reg)
            ST_SWEEP:
            begin
                ram_wr_en      = 1'b1;
                ram_wr_addr    = sweep_cnt_reg;
                ram_wr_data    = '0;
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (sweep_cnt_reg == SWEEP_END)
                begin
                    epoch_next = EPOCH_FIRST;
                    state_next = resume_reg ? ST_INSERT : ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                byte_stall = 1'b0;
                if (accept)
                begin
                    byte_next  = data_byte;
                    final_next = final_byte;
                    key_next   = key_in;
                    if (!have_pending_reg)
                    begin
                        pending_next      = CODE_BITS'(data_byte);
                        have_pending_next = 1'b1;
                        if (final_byte)
                        begin
                            state_next = ST_EMIT_LAST;
                        end
                    end
                    else
                    begin
                        ram_rd_en      = 1'b1;
                        ram_rd_addr    = hash_in;
                        home_idx_next  = hash_in;
                        probe_idx_next = hash_in;
                        state_next     = ST_PROBE;
                    end
                end
            end

            ST_PROBE:
            begin
                priority if (slot_hit)
                begin
                    pending_next = ram_rd_data.code;
                    state_next   = final_reg ? ST_EMIT_LAST : ST_IDLE;
                end
                else if (slot_live)
                begin
                    // Slot taken by another string: step to the next one.
                    ram_rd_en      = 1'b1;
                    ram_rd_addr    = probe_idx_reg + 1'b1;
                    probe_idx_next = probe_idx_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT_MISS;
                end
            end

            ST_EMIT_MISS:
            begin
                emit = '{valid: 1'b1, code: to_out_code(pending_reg), last: 1'b0};
                if (emit_ready)
                begin
                    if (next_free_reg >= NFC_FULL)
                    begin
                        // Dictionary full: drop back to the roots; the table is
                        // empty under the new epoch, so the home slot is free.
                        next_free_next = NFC_ROOT;
                        ins_idx_next   = home_idx_reg;
                        if (epoch_reg == EPOCH_LAST)
                        begin
                            resume_next    = 1'b1;
                            sweep_cnt_next = '0;
                            state_next     = ST_SWEEP;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + 1'b1;
                            state_next = ST_INSERT;
                        end
                    end
                    else
                    begin
                        ins_idx_next = probe_idx_reg;
                        state_next   = ST_INSERT;
                    end
                end
            end

            ST_INSERT:
            begin
                ram_wr_en      = 1'b1;
                next_free_next = next_free_reg + 1'b1;
                pending_next   = CODE_BITS'(byte_reg);
                state_next     = final_reg ? ST_EMIT_LAST : ST_IDLE;
            end

            ST_EMIT_LAST:
            begin
                emit = '{valid: 1'b1, code: to_out_code(pending_reg), last: 1'b1};
                if (emit_ready)
                begin
                    pending_next      = '0;
                    have_pending_next = 1'b0;
                    next_free_next    = NFC_ROOT;
                    if (epoch_reg == EPOCH_LAST)
                    begin
                        resume_next    = 1'b0;
                        sweep_cnt_next = '0;
                        state_next     = ST_SWEEP;
                    end
                    else
                    begin
                        epoch_next = epoch_reg + 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/lzw_encoder_12bit.sv @@
// LZW encoder, 12-bit codes. A byte that extends a known string is looked up in the hash
// table, with one more probe for each slot held by another string; a byte that misses also
// emits the pending code and inserts the new string; a final byte also emits the last code.
// The dictionary hash table sits in one synchronous RAM. After reset, and after every 63rd
// dictionary clear, a sweep that clears every slot of the RAM runs with byte_stall high.
// Reset is asynchronous and active low; the output register drains independently of the byte side.
`timescale 1ns / 1ps

module lzw_encoder_12bit
    import lzwe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  logic [BYTE_W-1:0]     data_byte,
    input  logic                  final_byte,
    output logic                  code_valid,
    input  logic                  code_stall,
    output logic [OUT_CODE_W-1:0] code,
    output logic                  last_code
);

    emit_t                 emit;
    logic                  emit_ready;
    logic                  ram_rd_en;
    logic [SLOT_BITS-1:0]  ram_rd_addr;
    logic [SLOT_W-1:0]     ram_rd_data;
    logic                  ram_wr_en;
    logic [SLOT_BITS-1:0]  ram_wr_addr;
    slot_t                 ram_wr_data;

    logic                  code_valid_reg, code_valid_next;
    logic [OUT_CODE_W-1:0] code_reg, code_next;
    logic                  last_code_reg, last_code_next;

    lzwe_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DICT_ENTRIES)
    ) u_dict_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    lzwe_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .data_byte   (data_byte),
        .final_byte  (final_byte),
        .emit        (emit),
        .emit_ready  (emit_ready),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (slot_t'(ram_rd_data)),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data)
    );

    // The output register takes a new code whenever it is empty or being emptied.
    assign emit_ready = !code_valid_reg || !code_stall;

    always_comb
    begin
        code_valid_next = code_valid_reg && code_stall;
        code_next       = code_reg;
        last_code_next  = last_code_reg;
        if (emit.valid && emit_ready)
        begin
            code_valid_next = 1'b1;
            code_next       = emit.code;
            last_code_next  = emit.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_valid_reg <= 1'b0;
        end
        else
        begin
            code_valid_reg <= code_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg      <= code_next;
        last_code_reg <= last_code_next;
    end

    assign code_valid = code_valid_reg;
    assign code       = code_reg;
    assign last_code  = last_code_reg;

endmodule

@@ design/lzwe_checker.sv @@
// Port-level checker for the LZW encoder, bound to the top level.
// Depends on lzwe_pkg and lzw_encoder_12bit.
`timescale 1ns / 1ps

module lzwe_checker
    import lzwe_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  byte_valid,
    input logic                  byte_stall,
    input logic                  final_byte,
    input logic                  code_valid,
    input logic                  code_stall,
    input logic [OUT_CODE_W-1:0] code,
    input logic                  last_code
);

    logic [1:0] finals_open_reg;
    logic       first_reg;
    logic       final_in;
    logic       code_taken;
    logic       last_out;

    assign final_in   = byte_valid && !byte_stall && final_byte;
    assign code_taken = code_valid && !code_stall;
    assign last_out   = code_taken && last_code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            finals_open_reg <= '0;
            first_reg       <= 1'b1;
        end
        else
        begin
            finals_open_reg <= finals_open_reg + 2'(final_in) - 2'(last_out);
            if (code_taken)
            begin
                first_reg <= last_code;
            end
        end
    end

    // A stalled transaction keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code_stall |=> code_valid && $stable(code) && $stable(last_code))
        else $error("output transaction changed while stalled");

    // The first code of every stream is a single-byte root.
    a_first_root: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && first_reg |-> code < OUT_CODE_W'(ROOT_CODES))
        else $error("first code of a stream is not a root code");

    // A closing code only follows a final byte that has not yet been closed.
    a_last_owed: assert property (@(posedge clk) disable iff (!rst_n)
        last_out |-> finals_open_reg != 2'd0)
        else $error("last code without a pending final byte");

    // At most one stream waits on its closing code while the next one finishes.
    a_finals_bound: assert property (@(posedge clk) disable iff (!rst_n)
        finals_open_reg != 2'd3)
        else $error("too many streams awaiting their last code");

endmodule

bind lzw_encoder_12bit lzwe_checker u_lzwe_checker (.*);
